[hw/rtl/whp_pkg.sv]
`default_nettype none

package whp_pkg;

   // result status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_TRUNC     = 4'd1;
   localparam logic [3:0] ST_NOT_WAVE  = 4'd2;
   localparam logic [3:0] ST_FMT_SHORT = 4'd3;
   localparam logic [3:0] ST_NOT_PCM   = 4'd4;
   localparam logic [3:0] ST_MISSING   = 4'd5;
   localparam logic [3:0] ST_BITS      = 4'd6;
   localparam logic [3:0] ST_CHANNELS  = 4'd7;
   localparam logic [3:0] ST_BYTE_RATE = 4'd8;

   // chunk tags as read little-endian
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FMT_PCM      = 16'd1;
   localparam logic [15:0] PCM_BITS     = 16'd16;
   localparam logic [15:0] CHAN_MONO    = 16'd1;
   localparam logic [15:0] CHAN_STEREO  = 16'd2;
   localparam logic [31:0] FMT_BODY_LEN = 32'd16;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] chan_count;
      logic [31:0] samp_rate;
      logic [31:0] bytes_per_sec;
      logic [15:0] samp_width;
      logic [31:0] payload_start;
      logic [31:0] payload_len;
   } res_type;

   // expected preamble bytes, size bytes are not checked
   function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h52; // R
         4'd1:    val = 8'h49; // I
         4'd2:    val = 8'h46; // F
         4'd3:    val = 8'h46; // F
         4'd8:    val = 8'h57; // W
         4'd9:    val = 8'h41; // A
         4'd10:   val = 8'h56; // V
         4'd11:   val = 8'h45; // E
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/wav_header_parser_top.sv]
`default_nettype none

// wav header parser: takes a wav file as a stream of byte words on the req_ channel, with
// req_end_of_file marking the last byte, checks the riff/wave preamble, walks the chunks
// (tag, little-endian length, pad byte after odd lengths), captures the fmt fields and
// gives one rsp_ word when the data chunk header is reached, on an error, or at end of file.
// bytes after a result are swallowed until end_of_file re-arms the parser. one byte word is
// taken every cycle: each byte passes an input register, one pass of shift, count and compare
// logic in the parse core, and the result register, which loads the result word as the byte
// that caused it leaves the input register. the only stall is a waiting result that rsp_ready holds back

module wav_header_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_file,
   // result output
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [3:0]  rsp_status,
   output      logic [15:0] rsp_chan_count,
   output      logic [31:0] rsp_samp_rate,
   output      logic [31:0] rsp_bytes_per_sec,
   output      logic [15:0] rsp_samp_width,
   output      logic [31:0] rsp_payload_start,
   output      logic [31:0] rsp_payload_len
);
   import whp_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   res_type    rsp_ff;

   logic       advance;
   logic       core_valid;
   res_type    core_res;

   // held byte moves on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? core_valid : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_file;
      end
      if (advance && core_valid) begin
         rsp_ff <= core_res;
      end
   end

   // parse state and per-byte decode
   whp_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .res_valid   (core_valid),
      .res         (core_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_chan_count    = rsp_ff.chan_count;
   assign rsp_samp_rate     = rsp_ff.samp_rate;
   assign rsp_bytes_per_sec = rsp_ff.bytes_per_sec;
   assign rsp_samp_width    = rsp_ff.samp_width;
   assign rsp_payload_start = rsp_ff.payload_start;
   assign rsp_payload_len   = rsp_ff.payload_len;

`ifndef ASSERT_OFF
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (advance && core_valid) |=> rsp_valid_ff)
      else $error("parser result lost");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (rsp_valid_ff && !rsp_ready))
      else $error("input held without a blocked result");
`endif

endmodule

`default_nettype wire

[hw/rtl/whp_parse_core.sv]
`default_nettype none

module whp_parse_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_file,
   output      logic            res_valid,
   output      whp_pkg::res_type res
);
   import whp_pkg::*;

   typedef enum logic [5:0] {
      PH_PRE_GOOD = 6'b000001,
      PH_PRE_BAD  = 6'b000010,
      PH_HDR      = 6'b000100,
      PH_FMT      = 6'b001000,
      PH_SKIP     = 6'b010000,
      PH_DONE     = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [3:0]  hbc_ff, hbc_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] skip_ff, skip_in;
   logic [15:0] fmt_code_ff, fmt_code_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] bits_ff, bits_in;
   logic        fmt_seen_ff, fmt_seen_in;

   logic [32:0] skip_amt;
   logic [31:0] fmt_rest;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff + 32'd1;
      hbc_in      = hbc_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      skip_in     = skip_ff;
      fmt_code_in = fmt_code_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      brate_in    = brate_ff;
      bits_in     = bits_ff;
      fmt_seen_in = fmt_seen_ff;
      res_valid   = 1'b0;
      res         = '0;
      skip_amt    = '0;
      fmt_rest    = len_ff - FMT_BODY_LEN;

      case (phase_ff)
         PH_PRE_GOOD, PH_PRE_BAD: begin
            if ((hbc_ff < 4'd4 || (hbc_ff >= 4'd8 && hbc_ff < 4'd12))
                && data_byte != preamble_byte(hbc_ff)) begin
               phase_in = PH_PRE_BAD;
            end
            if (hbc_ff >= 4'd11) begin
               hbc_in = '0;
               if (phase_in == PH_PRE_BAD) begin
                  res_valid  = 1'b1;
                  res.status = ST_NOT_WAVE;
                  phase_in   = PH_DONE;
               end else begin
                  phase_in = PH_HDR;
               end
            end else begin
               hbc_in = hbc_ff + 4'd1;
            end
         end
         PH_HDR: begin
            if (hbc_ff < 4'd4) begin
               tag_in = {data_byte, tag_ff[31:8]};
            end else begin
               len_in = {data_byte, len_ff[31:8]};
            end
            if (hbc_ff >= 4'd7) begin
               hbc_in = '0;
               if (tag_in == TAG_FMT) begin
                  if (len_in < FMT_BODY_LEN) begin
                     res_valid  = 1'b1;
                     res.status = ST_FMT_SHORT;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_FMT;
                  end
               end else if (tag_in == TAG_DATA) begin
                  res_valid = 1'b1;
                  if (!fmt_seen_ff) begin
                     res.status = ST_MISSING;
                  end else if (bits_ff != PCM_BITS) begin
                     res.status = ST_BITS;
                  end else if (chan_ff != CHAN_MONO && chan_ff != CHAN_STEREO) begin
                     res.status = ST_CHANNELS;
                  end else if (brate_ff == '0) begin
                     res.status = ST_BYTE_RATE;
                  end else begin
                     res.status = ST_OK;
                  end
                  res.payload_start = pos_in;
                  res.payload_len   = len_in;
                  phase_in          = PH_DONE;
               end else begin
                  // unknown chunk: skip body plus pad byte
                  skip_amt = {1'b0, len_in} + {32'd0, len_in[0]};
                  skip_in  = skip_amt;
                  phase_in = (skip_amt == '0) ? PH_HDR : PH_SKIP;
               end
            end else begin
               hbc_in = hbc_ff + 4'd1;
            end
         end
         PH_FMT: begin
            if (hbc_ff < 4'd2) begin
               fmt_code_in = {data_byte, fmt_code_ff[15:8]};
            end else if (hbc_ff < 4'd4) begin
               chan_in = {data_byte, chan_ff[15:8]};
            end else if (hbc_ff < 4'd8) begin
               rate_in = {data_byte, rate_ff[31:8]};
            end else if (hbc_ff < 4'd12) begin
               brate_in = {data_byte, brate_ff[31:8]};
            end else if (hbc_ff >= 4'd14) begin
               bits_in = {data_byte, bits_ff[15:8]};
            end
            if (hbc_ff >= 4'd15) begin
               hbc_in      = '0;
               fmt_seen_in = 1'b1;
               if (fmt_code_ff != FMT_PCM) begin
                  res_valid  = 1'b1;
                  res.status = ST_NOT_PCM;
                  phase_in   = PH_DONE;
               end else begin
                  // rest of fmt chunk plus pad byte
                  skip_amt = {1'b0, fmt_rest} + {32'd0, len_ff[0]};
                  skip_in  = skip_amt;
                  phase_in = (skip_amt == '0) ? PH_HDR : PH_SKIP;
               end
            end else begin
               hbc_in = hbc_ff + 4'd1;
            end
         end
         PH_SKIP: begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - 33'd1;
            end
            if (skip_in == '0) begin
               hbc_in   = '0;
               phase_in = PH_HDR;
            end
         end
         default: begin
         end
      endcase

      res.chan_count    = chan_in;
      res.samp_rate     = rate_in;
      res.bytes_per_sec = brate_in;
      res.samp_width    = bits_in;

      if (end_of_file) begin
         if (!res_valid) begin
            case (phase_in)
               PH_PRE_GOOD, PH_PRE_BAD, PH_FMT: begin
                  res_valid  = 1'b1;
                  res.status = ST_TRUNC;
               end
               PH_HDR: begin
                  res_valid  = 1'b1;
                  res.status = (hbc_in == '0) ? ST_MISSING : ST_TRUNC;
               end
               PH_SKIP: begin
                  res_valid  = 1'b1;
                  res.status = ST_MISSING;
               end
               default: begin
               end
            endcase
         end
         // re-arm for the next file
         phase_in    = PH_PRE_GOOD;
         pos_in      = '0;
         hbc_in      = '0;
         tag_in      = '0;
         len_in      = '0;
         skip_in     = '0;
         fmt_code_in = '0;
         chan_in     = '0;
         rate_in     = '0;
         brate_in    = '0;
         bits_in     = '0;
         fmt_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PRE_GOOD;
         pos_ff      <= '0;
         hbc_ff      <= '0;
         tag_ff      <= '0;
         len_ff      <= '0;
         skip_ff     <= '0;
         fmt_code_ff <= '0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         brate_ff    <= '0;
         bits_ff     <= '0;
         fmt_seen_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         hbc_ff      <= hbc_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         fmt_code_ff <= fmt_code_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         brate_ff    <= brate_in;
         bits_ff     <= bits_in;
         fmt_seen_ff <= fmt_seen_in;
      end
   end

`ifndef ASSERT_OFF
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_DONE) |-> !res_valid)
      else $error("result produced after parse finished");

   a_eof_rearm: assert property (@(posedge clock) disable iff (reset)
      (step && end_of_file) |=> (phase_ff == PH_PRE_GOOD && pos_ff == '0 && !fmt_seen_ff))
      else $error("parser not re-armed after end of file");
`endif

endmodule

`default_nettype wire
